// ===== rtl/tcp_keepalive_ack_rewriter_assert.svh =====
// Assertion macros for the TCP keepalive ACK rewriter.
`ifndef TCP_KEEPALIVE_ACK_REWRITER_ASSERT_SVH
`define TCP_KEEPALIVE_ACK_REWRITER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TKAR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TKAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tkar_pkg.sv =====
// Shared constants and types for the TCP keepalive ACK rewriter.
package tkar_pkg;

    localparam int unsigned FLOW_COUNT = 1024;
    localparam int unsigned FLOW_IDX_W = $clog2(FLOW_COUNT);
    localparam logic [31:0] FLOW_LIMIT = 32'(FLOW_COUNT);
    localparam logic [31:0] HALF_SPACE = 32'h8000_0000;

    localparam logic MODE_PACKET     = 1'b0;
    localparam logic MODE_HOST_WRITE = 1'b1;

    typedef struct packed {
        logic [31:0] last_seq;
        logic [31:0] previous_ack;
        logic [31:0] host_ack;
    } flow_entry_t;

    localparam int unsigned ENTRY_W = $bits(flow_entry_t);

    typedef struct packed {
        logic        mode;
        logic [31:0] flow_mark;
        logic [31:0] seq_number;
        logic [15:0] payload_length;
        logic        ack_flag;
        logic [31:0] host_ack_value;
    } item_t;

    typedef struct packed {
        logic        drop;
        logic        ack_rewrite;
        logic [31:0] new_ack;
        logic        seq_rewrite;
        logic [31:0] new_seq;
    } result_t;

endpackage

// ===== rtl/tkar_flow_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module tkar_flow_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned WIDTH  = 96,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/tkar_update.sv =====
// Per-transaction decision and table-entry update logic.
module tkar_update import tkar_pkg::*; (
    input  item_t       item,
    input  flow_entry_t entry,
    output result_t     result,
    output flow_entry_t new_entry,
    output logic        wr_en
);

    logic [31:0] flow_idx;
    logic        in_range;
    logic [31:0] seq_end;
    logic [31:0] seq_diff;
    logic        keepalive;
    logic        empty;

    assign flow_idx  = ~item.flow_mark;
    assign in_range  = flow_idx < FLOW_LIMIT;
    assign empty     = item.payload_length == 16'd0;
    assign seq_end   = item.seq_number + {16'd0, item.payload_length};
    assign seq_diff  = seq_end - entry.last_seq;
    assign keepalive = empty && (item.seq_number == (entry.last_seq - 32'd1));

    always_comb
    begin
        result    = '0;
        new_entry = entry;
        wr_en     = 1'b0;
        if (in_range)
        begin
            if (item.mode == MODE_HOST_WRITE)
            begin
                new_entry.host_ack = item.host_ack_value;
                wr_en              = 1'b1;
            end
            else if (item.ack_flag && (entry.host_ack == entry.previous_ack) && empty)
            begin
                // duplicate ack, no data
                result.drop = 1'b1;
            end
            else
            begin
                wr_en = 1'b1;
                if (item.ack_flag)
                begin
                    new_entry.previous_ack = entry.host_ack;
                    result.ack_rewrite     = 1'b1;
                    result.new_ack         = entry.host_ack;
                    if (keepalive)
                    begin
                        result.seq_rewrite = 1'b1;
                        result.new_seq     = entry.last_seq;
                    end
                end
                if ((seq_diff & HALF_SPACE) == 32'd0)
                begin
                    new_entry.last_seq = seq_end;
                end
            end
        end
    end

endmodule

// ===== rtl/tcp_keepalive_ack_rewriter.sv =====
// The table read is issued at accept; in S_EXEC, once the result register is free, the result
// is registered and any entry update written back. One transaction at a time: in_ready is low
// until the per-flow table RAM read-then-write-back ends, so its write precedes the next read.
// The result register frees the input side while a result waits for out_ready.
// Reset: async active low; then a clearing pass over all FLOW_COUNT (1024) entries zeroes the
// flow table, with in_ready low until it ends.
module tcp_keepalive_ack_rewriter import tkar_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] flow_mark,
    input  logic [31:0] seq_number,
    input  logic [15:0] payload_length,
    input  logic        ack_flag,
    input  logic [31:0] host_ack_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drop,
    output logic        ack_rewrite,
    output logic [31:0] new_ack,
    output logic        seq_rewrite,
    output logic [31:0] new_seq
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [FLOW_IDX_W-1:0] clr_idx_reg, clr_idx_next;
    item_t                 item_reg;
    result_t               res_reg;
    logic                  out_valid_reg, out_valid_next;

    logic                  in_fire;
    logic                  exec_go;
    logic                  upd_we;
    flow_entry_t           rd_entry;
    flow_entry_t           upd_entry;
    result_t               upd_result;
    logic                  mem_we;
    logic [FLOW_IDX_W-1:0] mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ENTRY_W-1:0]    mem_rdata;
    logic [FLOW_IDX_W-1:0] rd_addr;
    logic [FLOW_IDX_W-1:0] item_idx;

    assign in_ready = state_reg == S_IDLE;
    assign in_fire  = in_valid && in_ready;
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign rd_addr  = ~flow_mark[FLOW_IDX_W-1:0];
    assign item_idx = ~item_reg.flow_mark[FLOW_IDX_W-1:0];
    assign rd_entry = flow_entry_t'(mem_rdata);

    tkar_flow_ram #(
        .DEPTH (FLOW_COUNT),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    tkar_update u_update (
        .item      (item_reg),
        .entry     (rd_entry),
        .result    (upd_result),
        .new_entry (upd_entry),
        .wr_en     (upd_we)
    );

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = exec_go && upd_we;
            mem_waddr = item_idx;
            mem_wdata = ENTRY_W'(upd_entry);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == FLOW_IDX_W'(FLOW_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= '{mode: mode, flow_mark: flow_mark, seq_number: seq_number,
                          payload_length: payload_length, ack_flag: ack_flag,
                          host_ack_value: host_ack_value};
        end
        if (exec_go)
        begin
            res_reg <= upd_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drop        = res_reg.drop;
    assign ack_rewrite = res_reg.ack_rewrite;
    assign new_ack     = res_reg.new_ack;
    assign seq_rewrite = res_reg.seq_rewrite;
    assign new_seq     = res_reg.new_seq;

`include "tcp_keepalive_ack_rewriter_assert.svh"

    `TKAR_ASSERT_NEXT(a_accept_to_exec, in_fire, state_reg == S_EXEC, "accept did not enter exec")
    `TKAR_ASSERT_SAME(a_drop_clean, out_valid && drop, !ack_rewrite && !seq_rewrite, "drop with rewrite")
    `TKAR_ASSERT_SAME(a_seq_needs_ack, out_valid && seq_rewrite, ack_rewrite, "seq rewrite without ack rewrite")
    `TKAR_ASSERT_NEXT(a_exec_result, exec_go, out_valid, "exec finished without result")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the TCP keepalive ACK rewriter: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
    import tkar_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = MODE_PACKET;
    logic [31:0] flow_mark = '0;
    logic [31:0] seq_number = '0;
    logic [15:0] payload_length = '0;
    logic        ack_flag = 1'b0;
    logic [31:0] host_ack_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        drop;
    logic        ack_rewrite;
    logic [31:0] new_ack;
    logic        seq_rewrite;
    logic [31:0] new_seq;

    bit [31:0] flow_last_seq [FLOW_COUNT];
    bit [31:0] flow_prev_ack [FLOW_COUNT];
    bit [31:0] flow_host_ack [FLOW_COUNT];

    result_t expected_results [$];
    result_t oldest_result;
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    tcp_keepalive_ack_rewriter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .flow_mark      (flow_mark),
        .seq_number     (seq_number),
        .payload_length (payload_length),
        .ack_flag       (ack_flag),
        .host_ack_value (host_ack_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drop           (drop),
        .ack_rewrite    (ack_rewrite),
        .new_ack        (new_ack),
        .seq_rewrite    (seq_rewrite),
        .new_seq        (new_seq)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] mark_of(input int unsigned idx);
        return ~32'(idx);
    endfunction

    function automatic result_t predict_rewrite(input logic m, input logic [31:0] mark,
                                                input logic [31:0] seq, input logic [15:0] plen,
                                                input logic ackf, input logic [31:0] hval);
        result_t     res;
        logic [31:0] idx;
        logic [31:0] last;
        logic [31:0] next;
        logic [31:0] host;
        logic        keepalive;
        res = '0;
        idx = ~mark;
        if (idx >= FLOW_LIMIT)
            return res;
        if (m == MODE_HOST_WRITE)
        begin
            flow_host_ack[idx] = hval;
            return res;
        end
        last = flow_last_seq[idx];
        next = seq + 32'(plen);
        keepalive = (plen == 16'd0) && (seq == last - 32'd1);
        if (ackf)
        begin
            host = flow_host_ack[idx];
            if (host != flow_prev_ack[idx])
                flow_prev_ack[idx] = host;
            else if (plen == 16'd0)
            begin
                res.drop = 1'b1;
                return res;
            end
            res.ack_rewrite = 1'b1;
            res.new_ack = host;
            if (keepalive)
            begin
                res.seq_rewrite = 1'b1;
                res.new_seq = last;
            end
        end
        if (next - last < HALF_SPACE)
            flow_last_seq[idx] = next;
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic m, input logic [31:0] mark, input logic [31:0] seq,
                             input logic [15:0] plen, input logic ackf,
                             input logic [31:0] hval);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= m;
        flow_mark      <= mark;
        seq_number     <= seq;
        payload_length <= plen;
        ack_flag       <= ackf;
        host_ack_value <= hval;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_rewrite(m, mark, seq, plen, ackf, hval));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: result with no transaction pending", $realtime);
                mismatch_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (drop !== oldest_result.drop || ack_rewrite !== oldest_result.ack_rewrite ||
                    new_ack !== oldest_result.new_ack ||
                    seq_rewrite !== oldest_result.seq_rewrite ||
                    new_seq !== oldest_result.new_seq)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch exp drop=%b ack=%b/%h seq=%b/%h got %b %b/%h %b/%h",
                                 $realtime, oldest_result.drop, oldest_result.ack_rewrite,
                                 oldest_result.new_ack, oldest_result.seq_rewrite,
                                 oldest_result.new_seq, drop, ack_rewrite, new_ack,
                                 seq_rewrite, new_seq);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_out_of_range();
        send_item(MODE_PACKET, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(MODE_HOST_WRITE, mark_of(FLOW_COUNT), '0, '0, 1'b1, 32'hFFFF_FFFF);
        send_item(MODE_PACKET, mark_of(FLOW_COUNT), '0, '0, 1'b1, '0);
    endtask

    task automatic test_ack_drop();
        send_item(MODE_PACKET, mark_of(0), '0, '0, 1'b1, '0);
        send_item(MODE_HOST_WRITE, mark_of(0), '0, '0, 1'b0, 32'hFFFF_FFFF);
        send_item(MODE_PACKET, mark_of(0), '0, '0, 1'b1, '0);
        send_item(MODE_PACKET, mark_of(0), '0, '0, 1'b1, '0);
        send_item(MODE_PACKET, mark_of(0), 32'd5, 16'd10, 1'b1, '0);
    endtask

    task automatic test_host_write_last_flow();
        send_item(MODE_HOST_WRITE, mark_of(FLOW_COUNT - 1), '0, '0, 1'b0, '0);
        send_item(MODE_PACKET, mark_of(FLOW_COUNT - 1), '0, '0, 1'b1, '0);
        send_item(MODE_HOST_WRITE, mark_of(FLOW_COUNT - 1), '0, '0, 1'b0, 32'h1234_5678);
        send_item(MODE_PACKET, mark_of(FLOW_COUNT - 1), '0, '0, 1'b1, '0);
    endtask

    task automatic test_keepalive();
        send_item(MODE_PACKET, mark_of(2), 32'd1000, 16'd100, 1'b0, '0);
        send_item(MODE_HOST_WRITE, mark_of(2), '0, '0, 1'b0, 32'd77);
        send_item(MODE_PACKET, mark_of(2), 32'd1099, 16'd0, 1'b1, '0);
        send_item(MODE_PACKET, mark_of(2), 32'd1099, 16'd0, 1'b1, '0);
        send_item(MODE_HOST_WRITE, mark_of(2), '0, '0, 1'b0, 32'd78);
        send_item(MODE_PACKET, mark_of(2), 32'd1099, 16'd0, 1'b1, '0);
    endtask

    // Wraparound of seq + length and the half-space boundary of the serial compare.
    task automatic test_serial_compare();
        send_item(MODE_PACKET, mark_of(3), 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0);
        send_item(MODE_PACKET, mark_of(3), 32'd65534 + HALF_SPACE, 16'd0, 1'b0, '0);
        send_item(MODE_PACKET, mark_of(3), 32'd65533 + HALF_SPACE, 16'd0, 1'b0, '0);
        send_item(MODE_HOST_WRITE, mark_of(3), '0, '0, 1'b0, 32'hA5A5_5A5A);
        send_item(MODE_PACKET, mark_of(3), 32'd65532 + HALF_SPACE, 16'd0, 1'b1, '0);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int unsigned idx;
        int unsigned pick;
        logic [31:0] seq;
        logic [15:0] plen;
        logic [31:0] mark;
        logic        m;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            idx  = ($urandom_range(3) == 0) ? $urandom_range(FLOW_COUNT - 1)
                                            : $urandom_range(7);
            mark = mark_of(idx);
            m    = MODE_PACKET;
            pick = $urandom_range(99);
            case ($urandom_range(3))
                0:       plen = 16'd0;
                1:       plen = 16'($urandom);
                default: plen = 16'($urandom_range(1500));
            endcase
            seq = flow_last_seq[idx];
            if (pick < 8)
            begin
                mark = $urandom;
                m    = 1'($urandom);
            end
            else if (pick < 22)
                m = MODE_HOST_WRITE;
            else if (pick < 45)
            begin
                seq  = seq - 32'd1;
                plen = 16'd0;
            end
            else if (pick < 60)
                seq = seq - 32'($urandom_range(3000));
            else if (pick < 75)
                seq = $urandom;
            send_item(m, mark, seq, plen, ($urandom_range(99) < 85),
                      ($urandom_range(2) == 0) ? 32'($urandom_range(3)) : $urandom);
        end
        wait_for_results();
    endtask

    initial
    begin
        #4_000_000;
        $display("FAIL tcp_keepalive_ack_rewriter");
        $finish;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_out_of_range();
        test_ack_drop();
        test_host_write_last_flow();
        test_keepalive();
        test_serial_compare();
        wait_for_results();
        test_random_traffic(500, 0, 0);
        test_random_traffic(500, 56, 0);
        test_random_traffic(500, 0, 56);
        test_random_traffic(500, 32, 32);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS tcp_keepalive_ack_rewriter");
        else
            $display("FAIL tcp_keepalive_ack_rewriter");
        $finish;
    end

endmodule
